// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the neighbour search core.
// Clocked on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`endif

// ===== hw/rtl/cknn_pkg.sv =====
// Package of the cosine neighbour search core: defaults, register map, shared types.
// No dependencies.
package cknn_pkg;
  localparam int unsigned DefNumRows      = 256;
  localparam int unsigned DefNumColumns   = 256;
  localparam int unsigned DefMaxNeighbours = 16;
  localparam int unsigned SimW   = 17;
  localparam int unsigned RateW  = 4;
  localparam logic [SimW-1:0] SimOne = 17'h10000;

  localparam logic [1:0] REG_NCOUNT = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_AXIS   = 2'd2;

  typedef struct packed {
    logic            done;
    logic            zero;
    logic [SimW-1:0] sim;
  } cknn_sd_res_t;
endpackage

// ===== hw/rtl/cknn_store.sv =====
// Rating memory: one write port, two registered read ports, clearing pass after reset.
// Depends on cknn_pkg.
module cknn_store import cknn_pkg::*; #(
  parameter int unsigned RW = 8,
  parameter int unsigned CW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [RW-1:0]    wr_row_i,
  input  logic [CW-1:0]    wr_col_i,
  input  logic [RateW-1:0] wr_data_i,
  input  logic [RW-1:0]    a_row_i,
  input  logic [CW-1:0]    a_col_i,
  input  logic [RW-1:0]    b_row_i,
  input  logic [CW-1:0]    b_col_i,
  output logic [RateW-1:0] a_data_o,
  output logic [RateW-1:0] b_data_o,
  output logic             clearing_o
);
  localparam int unsigned AW = RW + CW;

  logic [RateW-1:0] mem [2**AW];
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             clr_q, clr_d;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [RateW-1:0] wdata;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (&clr_addr_q) begin
        clr_d = 1'b0;
      end
    end
    we    = clr_q | wr_en_i;
    waddr = clr_q ? clr_addr_q : {wr_row_i, wr_col_i};
    wdata = clr_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    a_data_o <= mem[{a_row_i, a_col_i}];
    b_data_o <= mem[{b_row_i, b_col_i}];
  end

  assign clearing_o = clr_q;
endmodule

// ===== hw/rtl/cknn_sqdiv.sv =====
// Shared iterative unit: integer square root, then restoring divide, one step a cycle.
// Depends on cknn_pkg.
module cknn_sqdiv import cknn_pkg::*; #(
  parameter int unsigned NW = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [2*NW-1:0] prod_i,
  input  logic [NW-1:0]   dot_i,
  output cknn_sd_res_t    res_o
);
  localparam int unsigned QW = NW + 16;
  localparam int unsigned XW = 2 * NW + 1;
  localparam int unsigned CTW = $clog2(QW + 1);

  typedef enum logic [2:0] {
    SD_IDLE = 3'b001,
    SD_ROOT = 3'b010,
    SD_DIV  = 3'b100
  } sd_state_e;

  sd_state_e        st_q, st_d;
  logic [CTW-1:0]   cnt_q, cnt_d;
  logic [XW-1:0]    v_q, v_d, r_q, r_d, b_q, b_d;
  logic [QW-1:0]    num_q, num_d, quo_q, quo_d;
  logic [NW:0]      rem_q, rem_d;
  logic             done_q, done_d;
  logic [XW-1:0]    rb;
  logic [NW+1:0]    r2;
  logic [NW-1:0]    root;

  assign rb   = r_q + b_q;
  assign root = r_q[NW-1:0];
  assign r2   = {rem_q, num_q[QW-1]};

  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    v_d    = v_q;
    r_d    = r_q;
    b_d    = b_q;
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    case (st_q)
      SD_IDLE: begin
        if (start_i) begin
          v_d   = XW'(prod_i);
          r_d   = '0;
          b_d   = XW'(1) << (2 * NW - 2);
          num_d = {dot_i, 16'h0000};
          quo_d = '0;
          rem_d = '0;
          cnt_d = CTW'(NW);
          st_d  = SD_ROOT;
        end
      end
      SD_ROOT: begin
        if (v_q >= rb) begin
          v_d = v_q - rb;
          r_d = (r_q >> 1) + b_q;
        end else begin
          r_d = r_q >> 1;
        end
        b_d   = b_q >> 2;
        cnt_d = cnt_q - CTW'(1);
        if (cnt_q == CTW'(1)) begin
          cnt_d = CTW'(QW);
          st_d  = (r_d == '0) ? SD_IDLE : SD_DIV;
          done_d = (r_d == '0);
        end
      end
      SD_DIV: begin
        num_d = num_q << 1;
        if (r2 >= (NW+2)'(root)) begin
          rem_d = (NW+1)'(r2 - (NW+2)'(root));
          quo_d = {quo_q[QW-2:0], 1'b1};
        end else begin
          rem_d = r2[NW:0];
          quo_d = {quo_q[QW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CTW'(1);
        if (cnt_q == CTW'(1)) begin
          st_d   = SD_IDLE;
          done_d = 1'b1;
        end
      end
      default: st_d = SD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= SD_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    v_q   <= v_d;
    r_q   <= r_d;
    b_q   <= b_d;
    num_q <= num_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  always_comb begin
    res_o.done = done_q;
    res_o.zero = (r_q == '0);
    res_o.sim  = (quo_q > QW'(SimOne)) ? SimOne : quo_q[SimW-1:0];
  end
endmodule

// ===== hw/rtl/cknn_rank.sv =====
// Sorted top-k list of neighbours with registered insertion and an indexed read.
// Depends on cknn_pkg.
module cknn_rank import cknn_pkg::*; #(
  parameter int unsigned MN = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clr_i,
  input  logic                        ins_i,
  input  logic [7:0]                  idx_i,
  input  logic [SimW-1:0]             score_i,
  input  logic [$clog2(MN+1)-1:0]     k_i,
  input  logic [((MN>1)?$clog2(MN):1)-1:0] rd_i,
  output logic [7:0]                  rd_idx_o,
  output logic [SimW-1:0]             rd_score_o,
  output logic [$clog2(MN+1)-1:0]     cnt_o
);
  localparam int unsigned KW = $clog2(MN + 1);

  logic [7:0]      idx_q [MN];
  logic [SimW-1:0] sc_q  [MN];
  logic [7:0]      idx_d [MN];
  logic [SimW-1:0] sc_d  [MN];
  logic [MN-1:0]   ge;
  logic            ok;
  logic [KW-1:0]   cnt_q, cnt_d;

  always_comb begin
    ok = 1'b0;
    for (int i = 0; i < MN; i++) begin
      ge[i] = (32'(i) < 32'(cnt_q)) && (sc_q[i] >= score_i);
      if ((32'(i) < 32'(k_i)) && !ge[i]) begin
        ok = 1'b1;
      end
    end
    for (int i = 0; i < MN; i++) begin
      idx_d[i] = idx_q[i];
      sc_d[i]  = sc_q[i];
      if (ins_i && ok && !ge[i]) begin
        if (i == 0) begin
          idx_d[i] = idx_i;
          sc_d[i]  = score_i;
        end else if (ge[i-1]) begin
          idx_d[i] = idx_i;
          sc_d[i]  = score_i;
        end else begin
          idx_d[i] = idx_q[i-1];
          sc_d[i]  = sc_q[i-1];
        end
      end
    end
    cnt_d = cnt_q;
    if (clr_i) begin
      cnt_d = '0;
    end else if (ins_i && ok && (cnt_q < k_i)) begin
      cnt_d = cnt_q + KW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MN; i++) begin
      idx_q[i] <= idx_d[i];
      sc_q[i]  <= sc_d[i];
    end
  end

  assign rd_idx_o   = idx_q[rd_i];
  assign rd_score_o = sc_q[rd_i];
  assign cnt_o      = cnt_q;
endmodule

// ===== hw/rtl/cosine_knn_neighbour_search_core.sv =====
// Top level of the cosine-similarity neighbour search core: APB registers and sequencer.
// Depends on cknn_pkg, cknn_store, cknn_sqdiv, cknn_rank and assert_macros.svh.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   command  | start / busy           | op_i, row_index_i, column_index_i, rating_value_i,
//            |                        | target_index_i
//   result   | valid_o (one cycle)    | neighbour_index_o, similarity_o, found_o, last_o
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// After reset the rating memory is swept clear; busy stays high meanwhile. The length of
// a query is set by the single memory scan per vector and by the shared root/divide unit,
// which runs only for vectors with a nonzero dot product with the target. Results leave
// one per cycle; the receiver cannot stall them.
`include "assert_macros.svh"
module cosine_knn_neighbour_search_core import cknn_pkg::*; #(
  parameter int unsigned NUM_ROWS       = DefNumRows,
  parameter int unsigned NUM_COLUMNS    = DefNumColumns,
  parameter int unsigned MAX_NEIGHBOURS = DefMaxNeighbours
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic             op_i,
  input  logic [7:0]       row_index_i,
  input  logic [7:0]       column_index_i,
  input  logic [RateW-1:0] rating_value_i,
  input  logic [7:0]       target_index_i,
  output logic             valid_o,
  output logic [7:0]       neighbour_index_o,
  output logic [SimW-1:0]  similarity_o,
  output logic             found_o,
  output logic             last_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned RW = $clog2(NUM_ROWS);
  localparam int unsigned CW = $clog2(NUM_COLUMNS);
  localparam int unsigned VW = (RW > CW) ? RW : CW;
  localparam int unsigned LenMax = (NUM_ROWS > NUM_COLUMNS) ? NUM_ROWS : NUM_COLUMNS;
  localparam int unsigned NW = $clog2(225 * LenMax + 1);
  localparam int unsigned KW = $clog2(MAX_NEIGHBOURS + 1);
  localparam int unsigned IW = (MAX_NEIGHBOURS > 1) ? $clog2(MAX_NEIGHBOURS) : 1;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_TNORM  = 10'b0000000010,
    ST_VEC    = 10'b0000000100,
    ST_DRAIN  = 10'b0000001000,
    ST_CHECK  = 10'b0000010000,
    ST_LAUNCH = 10'b0000100000,
    ST_WAIT   = 10'b0001000000,
    ST_RANK   = 10'b0010000000,
    ST_NEXT   = 10'b0100000000,
    ST_EMIT   = 10'b1000000000
  } state_e;

  // configuration
  logic [4:0]      ncount_q;
  logic [SimW-1:0] thr_q;
  logic            axis_q;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncount_q <= 5'd10;
      thr_q    <= '0;
      axis_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_NCOUNT: ncount_q <= pwdata[4:0];
        REG_THRESH: thr_q    <= pwdata[SimW-1:0];
        REG_AXIS:   axis_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_NCOUNT: prdata = 32'(ncount_q);
      REG_THRESH: prdata = 32'(thr_q);
      REG_AXIS:   prdata = 32'(axis_q);
      default:    prdata = '0;
    endcase
  end

  // sequencer
  state_e          state_q, state_d;
  logic [VW:0]     j_q, j_d, p_q, p_d;
  logic [VW-1:0]   tgt_q, tgt_d;
  logic [KW-1:0]   k_q, k_d;
  logic [IW-1:0]   e_q, e_d;
  logic [NW-1:0]   tn_q, tn_d, dot_q, dot_d, own_q, own_d;
  logic [2*NW-1:0] prod_q, prod_d;
  logic            phase_t_q, phase_t_d;
  logic            acc_q, acc_d;
  logic [VW:0]     nvec, len;
  logic            clearing;
  logic [RateW-1:0] rd_a, rd_b;
  logic [VW:0]     vec_a, vec_b;
  logic [RW-1:0]   a_row, b_row;
  logic [CW-1:0]   a_col, b_col;
  logic            accept, wr_ok, q_ok;
  logic [KW-1:0]   k_sel;
  cknn_sd_res_t    sd_res;
  logic            sd_start;
  logic            rk_clr, rk_ins;
  logic [7:0]      rk_idx;
  logic [SimW-1:0] rk_score;
  logic [KW-1:0]   rk_cnt;

  assign nvec   = axis_q ? (VW+1)'(NUM_COLUMNS) : (VW+1)'(NUM_ROWS);
  assign len    = axis_q ? (VW+1)'(NUM_ROWS) : (VW+1)'(NUM_COLUMNS);
  assign busy   = clearing | (state_q != ST_IDLE);
  assign accept = start & ~busy;
  assign wr_ok  = (32'(row_index_i) < NUM_ROWS) && (32'(column_index_i) < NUM_COLUMNS);
  assign k_sel  = (32'(ncount_q) > MAX_NEIGHBOURS) ? KW'(MAX_NEIGHBOURS) : KW'(ncount_q);
  assign q_ok   = (32'(target_index_i) < 32'(nvec)) && (ncount_q != '0);

  always_comb begin
    vec_a = (state_q == ST_TNORM) ? (VW+1)'(tgt_q) : j_q;
    vec_b = (VW+1)'(tgt_q);
    if (axis_q) begin
      a_row = RW'(p_q);
      a_col = CW'(vec_a);
      b_row = RW'(p_q);
      b_col = CW'(vec_b);
    end else begin
      a_row = RW'(vec_a);
      a_col = CW'(p_q);
      b_row = RW'(vec_b);
      b_col = CW'(p_q);
    end
  end

  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    p_d       = p_q;
    tgt_d     = tgt_q;
    k_d       = k_q;
    e_d       = e_q;
    tn_d      = tn_q;
    dot_d     = dot_q;
    own_d     = own_q;
    prod_d    = prod_q;
    phase_t_d = phase_t_q;
    acc_d     = 1'b0;
    sd_start  = 1'b0;
    rk_clr    = 1'b0;
    rk_ins    = 1'b0;
    if (acc_q) begin
      if (phase_t_q) begin
        tn_d = tn_q + NW'(rd_a * rd_a);
      end else begin
        dot_d = dot_q + NW'(rd_a * rd_b);
        own_d = own_q + NW'(rd_a * rd_a);
      end
    end
    case (state_q)
      ST_IDLE: begin
        if (accept && op_i) begin
          rk_clr    = 1'b1;
          e_d       = '0;
          k_d       = k_sel;
          tgt_d     = VW'(target_index_i);
          tn_d      = '0;
          p_d       = '0;
          phase_t_d = 1'b1;
          state_d   = q_ok ? ST_TNORM : ST_EMIT;
        end
      end
      ST_TNORM, ST_VEC: begin
        acc_d = 1'b1;
        p_d   = p_q + (VW+1)'(1);
        if (p_d == len) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_CHECK;
      ST_CHECK: begin
        if (phase_t_q) begin
          phase_t_d = 1'b0;
          j_d       = '0;
          state_d   = ST_NEXT;
        end else if (dot_q == '0) begin
          j_d     = j_q + (VW+1)'(1);
          state_d = ST_NEXT;
        end else begin
          prod_d  = (2*NW)'(own_q) * (2*NW)'(tn_q);
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        sd_start = 1'b1;
        state_d  = ST_WAIT;
      end
      ST_WAIT: begin
        if (sd_res.done) begin
          state_d = ST_RANK;
        end
      end
      ST_RANK: begin
        rk_ins  = !sd_res.zero && (sd_res.sim >= thr_q);
        j_d     = j_q + (VW+1)'(1);
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        if (j_q == nvec) begin
          state_d = ST_EMIT;
        end else if (j_q == (VW+1)'(tgt_q)) begin
          j_d = j_q + (VW+1)'(1);
        end else begin
          dot_d   = '0;
          own_d   = '0;
          p_d     = '0;
          state_d = ST_VEC;
        end
      end
      ST_EMIT: begin
        e_d = e_q + IW'(1);
        if (last_o) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_q     <= 1'b0;
      phase_t_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_q     <= acc_d;
      phase_t_q <= phase_t_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q    <= j_d;
    p_q    <= p_d;
    tgt_q  <= tgt_d;
    k_q    <= k_d;
    e_q    <= e_d;
    tn_q   <= tn_d;
    dot_q  <= dot_d;
    own_q  <= own_d;
    prod_q <= prod_d;
  end

  cknn_store #(.RW(RW), .CW(CW)) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (accept & ~op_i & wr_ok),
    .wr_row_i   (RW'(row_index_i)),
    .wr_col_i   (CW'(column_index_i)),
    .wr_data_i  (rating_value_i),
    .a_row_i    (a_row),
    .a_col_i    (a_col),
    .b_row_i    (b_row),
    .b_col_i    (b_col),
    .a_data_o   (rd_a),
    .b_data_o   (rd_b),
    .clearing_o (clearing)
  );

  cknn_sqdiv #(.NW(NW)) u_sqdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sd_start),
    .prod_i  (prod_q),
    .dot_i   (dot_q),
    .res_o   (sd_res)
  );

  cknn_rank #(.MN(MAX_NEIGHBOURS)) u_rank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (rk_clr),
    .ins_i      (rk_ins),
    .idx_i      (8'(j_q)),
    .score_i    (sd_res.sim),
    .k_i        (k_q),
    .rd_i       (e_q),
    .rd_idx_o   (rk_idx),
    .rd_score_o (rk_score),
    .cnt_o      (rk_cnt)
  );

  always_comb begin
    valid_o = (state_q == ST_EMIT);
    found_o = (rk_cnt != '0);
    if (found_o) begin
      neighbour_index_o = rk_idx;
      similarity_o      = rk_score;
      last_o            = (KW'(e_q) + KW'(1) == rk_cnt);
    end else begin
      neighbour_index_o = '0;
      similarity_o      = '0;
      last_o            = 1'b1;
    end
  end

  `ASSERT_IMPL(a_strobe_in_emit, valid_o, (state_q == ST_EMIT) && !clearing)
  `ASSERT_NEXT(a_last_ends_query, valid_o && last_o, (state_q == ST_IDLE) && !valid_o)
  `ASSERT_NEXT(a_unit_done_ranks, (state_q == ST_WAIT) && sd_res.done, state_q == ST_RANK)
endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench of cosine_knn_neighbour_search_core: rating writes and neighbour queries
// are predicted in SystemVerilog and checked result by result. Needs cknn_pkg and the core RTL.
module tb_top;
  import cknn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NR = 256;
  localparam int unsigned WATCHDOG_LIMIT = 400000;
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct {
    logic [7:0]      idx;
    logic [SimW-1:0] sim;
    logic            found;
    logic            last;
  } nbr_res_t;

  class neighbour_ledger;
    nbr_res_t    pending[$];
    int unsigned errors;
    int unsigned checked;

    function void note_query(nbr_res_t answer[$]);
      foreach (answer[i]) pending.push_back(answer[i]);
    endfunction

    function void check_result(nbr_res_t got);
      nbr_res_t exp_r;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected result: index %0d similarity %0d", got.idx, got.sim);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.idx !== exp_r.idx) begin
        $error("neighbour_index: expected %0d actual %0d", exp_r.idx, got.idx);
        errors++;
      end
      if (got.sim !== exp_r.sim) begin
        $error("similarity: expected %0d actual %0d", exp_r.sim, got.sim);
        errors++;
      end
      if (got.found !== exp_r.found) begin
        $error("found: expected %0d actual %0d", exp_r.found, got.found);
        errors++;
      end
      if (got.last !== exp_r.last) begin
        $error("last: expected %0d actual %0d", exp_r.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic op_i = 1'b0;
  logic [7:0] row_index_i = '0;
  logic [7:0] column_index_i = '0;
  logic [RateW-1:0] rating_value_i = '0;
  logic [7:0] target_index_i = '0;
  logic valid_o;
  logic [7:0] neighbour_index_o;
  logic [SimW-1:0] similarity_o;
  logic found_o;
  logic last_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  cosine_knn_neighbour_search_core dut (
    .clk_i, .rst_ni, .start, .busy, .op_i, .row_index_i, .column_index_i, .rating_value_i,
    .target_index_i, .valid_o, .neighbour_index_o, .similarity_o, .found_o, .last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  neighbour_ledger ledger = new();

  logic [RateW-1:0] ratings [NR][NR];
  int unsigned      cfg_count = 10;
  int unsigned      cfg_thresh = 0;
  bit               cfg_axis = 1'b0;
  bit               gaps_on = 1'b1;
  int unsigned      n_items, n_queries, n_settings;
  int unsigned      quiet_cycles;

  always @(posedge clk_i) begin
    nbr_res_t got;
    if (rst_ni && valid_o) begin
      got.idx = neighbour_index_o;
      got.sim = similarity_o;
      got.found = found_o;
      got.last = last_o;
      ledger.check_result(got);
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int unsigned cell_at(int unsigned vec, int unsigned pos);
    return cfg_axis ? 32'(ratings[pos][vec]) : 32'(ratings[vec][pos]);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root = 0;
    longint unsigned trial;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void rank_neighbours(int unsigned tgt, ref nbr_res_t answer[$]);
    int unsigned     cand_idx[$];
    longint unsigned cand_sim[$];
    longint unsigned tnorm, dot, own, root, sim;
    int unsigned     k, pick, t;
    nbr_res_t        r;
    answer.delete();
    k = (cfg_count > 16) ? 16 : cfg_count;
    if (k > 0) begin
      tnorm = 0;
      for (int p = 0; p < NR; p++) tnorm += 64'(cell_at(tgt, p) * cell_at(tgt, p));
      for (int j = 0; j < NR; j++) begin
        if (j == tgt) continue;
        dot = 0;
        own = 0;
        for (int p = 0; p < NR; p++) begin
          t = cell_at(j, p);
          dot += 64'(t * cell_at(tgt, p));
          own += 64'(t * t);
        end
        if (dot == 0) continue;
        root = int_sqrt(own * tnorm);
        if (root == 0) continue;
        sim = (dot << 16) / root;
        if (sim > 65536) sim = 65536;
        if (sim >= 64'(cfg_thresh)) begin
          cand_idx.push_back(j);
          cand_sim.push_back(sim);
        end
      end
      while (answer.size() < k && cand_idx.size() > 0) begin
        pick = 0;
        foreach (cand_idx[i])
          if (cand_sim[i] > cand_sim[pick]) pick = i;
        r.idx = 8'(cand_idx[pick]);
        r.sim = SimW'(cand_sim[pick]);
        r.found = 1'b1;
        r.last = 1'b0;
        answer.push_back(r);
        cand_idx.delete(pick);
        cand_sim.delete(pick);
      end
    end
    if (answer.size() == 0) begin
      r.idx = '0;
      r.sim = '0;
      r.found = 1'b0;
      r.last = 1'b1;
      answer.push_back(r);
    end else begin
      answer[answer.size()-1].last = 1'b1;
    end
  endfunction

  task automatic send_command(logic op, logic [7:0] row, logic [7:0] col,
                              logic [RateW-1:0] val, logic [7:0] tgt);
    nbr_res_t answer[$];
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    row_index_i <= row;
    column_index_i <= col;
    rating_value_i <= val;
    target_index_i <= tgt;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    n_items++;
    if (op == OP_WRITE) begin
      ratings[row][col] = val;
    end else begin
      n_queries++;
      rank_neighbours(32'(tgt), answer);
      ledger.note_query(answer);
    end
  endtask

  task automatic settle;
    start <= 1'b0;
    @(posedge clk_i);
    while (ledger.pending.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] regi, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {regi, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (regi)
      REG_NCOUNT: cfg_count = 32'(value[4:0]);
      REG_THRESH: cfg_thresh = 32'(value[16:0]);
      REG_AXIS:   cfg_axis = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [4:0] cnt, logic [16:0] thr, logic ax);
    settle();
    write_reg(REG_NCOUNT, {27'd0, cnt});
    write_reg(REG_THRESH, {15'd0, thr});
    write_reg(REG_AXIS, {31'd0, ax});
    n_settings++;
  endtask

  task automatic random_items(int unsigned num);
    logic [7:0] a, b;
    for (int i = 0; i < num; i++) begin
      if ($urandom_range(0, 99) < 80) begin
        if ($urandom_range(0, 99) < 85) begin
          a = 8'($urandom_range(0, 7));
          b = 8'($urandom_range(0, 7));
        end else begin
          a = 8'($urandom_range(0, 255));
          b = 8'($urandom_range(0, 255));
        end
        send_command(OP_WRITE, a, b, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else begin
        a = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        send_command(OP_QUERY, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     4'($urandom_range(0, 15)), a);
      end
    end
  endtask

  initial begin
    foreach (ratings[r, c]) ratings[r][c] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed cases: rows 0 and 1 are identical and give full similarity, then corner-case queries and settings
    send_command(OP_WRITE, 8'd0, 8'd0, 4'd15, 8'd0);
    send_command(OP_WRITE, 8'd0, 8'd255, 4'd7, 8'd0);
    send_command(OP_WRITE, 8'd1, 8'd0, 4'd15, 8'd0);
    send_command(OP_WRITE, 8'd1, 8'd255, 4'd7, 8'd0);
    send_command(OP_WRITE, 8'd255, 8'd255, 4'd11, 8'd0);
    send_command(OP_WRITE, 8'd255, 8'd0, 4'd1, 8'd0);
    send_command(OP_WRITE, 8'd2, 8'd0, 4'd3, 8'd0);
    send_command(OP_WRITE, 8'd2, 8'd1, 4'd5, 8'd0);
    send_command(OP_WRITE, 8'd3, 8'd1, 4'd9, 8'd0);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd0);
    send_command(OP_QUERY, 8'hFF, 8'hFF, 4'hF, 8'd255);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd100);
    send_command(OP_WRITE, 8'd1, 8'd255, 4'd0, 8'hFF);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd1);
    configure(5'd1, 17'd0, 1'b1);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd0);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd255);
    configure(5'd0, 17'd0, 1'b0);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd0);
    configure(5'd31, 17'h1FFFF, 1'b0);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd2);
    configure(5'd16, 17'd65536, 1'b0);
    send_command(OP_QUERY, 8'd0, 8'd0, 4'd0, 8'd0);

    configure(5'd16, 17'd0, 1'b0);
    random_items(25);
    configure(5'd3, 17'd30000, 1'b1);
    random_items(25);
    configure(5'd31, 17'($urandom_range(0, 65536)), 1'b0);
    random_items(25);
    configure(5'($urandom_range(1, 16)), 17'($urandom_range(0, 50000)),
              1'($urandom_range(0, 1)));
    gaps_on = 1'b0;
    random_items(25);

    settle();
    repeat (50) @(posedge clk_i);
    $display("Ran %0d commands (%0d queries) over %0d register settings.",
             n_items, n_queries, n_settings);
    $display("Checked %0d neighbour results.", ledger.checked);
    if (ledger.errors == 0 && ledger.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
